// File: hw/rtl/lcfd_pkg.sv
// shared types, constants and crc function for the length/crc frame deframer
package lcfd_pkg;

  localparam int          MAX_PAYLOAD  = 32;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;
  localparam logic [7:0]  MARKER_RESET = 8'h7E;

  typedef enum logic [4:0] {
    ST_HUNT  = 5'b00001,
    ST_LEN   = 5'b00010,
    ST_DATA  = 5'b00100,
    ST_CRC   = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  // crc-16 ccitt-false, one byte, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/lcfd_ram.sv
// generic single-write, single-read ram with registered read data
module lcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/length_crc_frame_deframer_unit.sv
// length-prefixed frame deframer with crc-16 ccitt-false check and payload buffer
// input: one byte per cycle in hunt, length, payload and crc phases; no input during drain
// first result: after the crc low byte the block enters drain, reads the ram and registers the byte at the output
// drain: one result per cycle from the payload ram (one read port, registered read) while out_ready
//   is high; a good frame holds off input until all of its bytes have been read from the ram
// reset: synchronous, active low; control state cleared, start marker back to 0x7E,
//   payload ram not cleared (entries are read only after being written)
module length_crc_frame_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic [4:0] out_byte_index,
  output logic [5:0] out_frame_length,
  output logic       out_last
);

  localparam int CW = $clog2(lcfd_pkg::MAX_PAYLOAD + 1);
  localparam int AW = (lcfd_pkg::MAX_PAYLOAD > 1) ? $clog2(lcfd_pkg::MAX_PAYLOAD) : 1;

  lcfd_pkg::state_t state_r, state_nxt;
  logic [7:0]    marker_r;
  logic [15:0]   crc_r, crc_nxt, crc_in;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [CW-1:0] len_r, len_nxt;
  logic [7:0]    crc_hi_r, crc_hi_nxt;
  logic          crc_cnt_r, crc_cnt_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt, rd_cnt_inc;

  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_idx_r;
  logic [CW-1:0] pend_len_r;
  logic          pend_last_r;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic [CW-1:0] out_idx_r;
  logic [CW-1:0] out_len_r;
  logic          out_last_r;

  logic          in_acc;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic          issue;
  logic          load;
  logic          len_ok;

  assign in_ready = (state_r != lcfd_pkg::ST_DRAIN);
  assign in_acc   = in_valid && in_ready;
  assign crc_in   = lcfd_pkg::crc_feed(
                      (state_r == lcfd_pkg::ST_HUNT) ? lcfd_pkg::CRC_INIT : crc_r, in_rx_byte);
  assign cnt_inc    = cnt_r + CW'(1);
  assign rd_cnt_inc = rd_cnt_r + CW'(1);
  assign len_ok     = (in_rx_byte != 8'd0) && (in_rx_byte <= 8'(lcfd_pkg::MAX_PAYLOAD));

  // ram output stays put until the next read, so it doubles as a skid slot
  assign load  = pend_r && (!out_valid_r || out_ready);
  assign issue = (state_r == lcfd_pkg::ST_DRAIN) && (!pend_r || load);
  assign ram_we = in_acc && (state_r == lcfd_pkg::ST_DATA);

  lcfd_ram #(
    .WIDTH (8),
    .DEPTH (lcfd_pkg::MAX_PAYLOAD)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_rx_byte),
    .re    (issue),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    crc_nxt     = crc_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    crc_hi_nxt  = crc_hi_r;
    crc_cnt_nxt = crc_cnt_r;
    rd_cnt_nxt  = rd_cnt_r;
    case (state_r)
      lcfd_pkg::ST_HUNT: begin
        if (in_acc && (in_rx_byte == marker_r)) begin
          crc_nxt     = crc_in;
          cnt_nxt     = '0;
          len_nxt     = '0;
          crc_cnt_nxt = 1'b0;
          crc_hi_nxt  = 8'd0;
          state_nxt   = lcfd_pkg::ST_LEN;
        end
      end
      lcfd_pkg::ST_LEN: begin
        if (in_acc) begin
          if (len_ok) begin
            len_nxt   = in_rx_byte[CW-1:0];
            cnt_nxt   = '0;
            crc_nxt   = crc_in;
            state_nxt = lcfd_pkg::ST_DATA;
          end else begin
            state_nxt = lcfd_pkg::ST_HUNT;
          end
        end
      end
      lcfd_pkg::ST_DATA: begin
        if (in_acc) begin
          cnt_nxt = cnt_inc;
          crc_nxt = crc_in;
          if (cnt_inc >= len_r) begin
            crc_cnt_nxt = 1'b0;
            crc_hi_nxt  = 8'd0;
            state_nxt   = lcfd_pkg::ST_CRC;
          end
        end
      end
      lcfd_pkg::ST_CRC: begin
        if (in_acc) begin
          if (!crc_cnt_r) begin
            crc_hi_nxt  = in_rx_byte;
            crc_cnt_nxt = 1'b1;
          end else begin
            crc_cnt_nxt = 1'b0;
            rd_cnt_nxt  = '0;
            if ({crc_hi_r, in_rx_byte} == crc_r) begin
              state_nxt = lcfd_pkg::ST_DRAIN;
            end else begin
              state_nxt = lcfd_pkg::ST_HUNT;
            end
          end
        end
      end
      lcfd_pkg::ST_DRAIN: begin
        if (issue) begin
          rd_cnt_nxt = rd_cnt_inc;
          if (rd_cnt_inc == len_r) begin
            state_nxt = lcfd_pkg::ST_HUNT;
          end
        end
      end
      default: begin
        state_nxt = lcfd_pkg::ST_HUNT;
      end
    endcase
  end

  assign pend_nxt      = issue ? 1'b1 : (load ? 1'b0 : pend_r);
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcfd_pkg::ST_HUNT;
      marker_r    <= lcfd_pkg::MARKER_RESET;
      crc_r       <= lcfd_pkg::CRC_INIT;
      cnt_r       <= '0;
      len_r       <= '0;
      crc_hi_r    <= 8'd0;
      crc_cnt_r   <= 1'b0;
      rd_cnt_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crc_r       <= crc_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      crc_hi_r    <= crc_hi_nxt;
      crc_cnt_r   <= crc_cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        marker_r <= cfg_wr_data;
      end
    end
  end

  // result sideband travels with the read it belongs to
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx_r  <= rd_cnt_r;
      pend_len_r  <= len_r;
      pend_last_r <= (rd_cnt_inc == len_r);
    end
    if (load) begin
      out_byte_r <= ram_rdata;
      out_idx_r  <= pend_idx_r;
      out_len_r  <= pend_len_r;
      out_last_r <= pend_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = 5'(out_idx_r);
  assign out_frame_length = 6'(out_len_r);
  assign out_last         = out_last_r;

endmodule

// File: hw/rtl/lcfd_checker.sv
// port-level checker for the deframer, bound to the top level
module lcfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_wr_en,
  input logic [7:0] cfg_wr_data,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload_byte,
  input logic [4:0] out_byte_index,
  input logic [5:0] out_frame_length,
  input logic       out_last
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_byte_index) && $stable(out_frame_length) && $stable(out_last))
    else $error("stalled result changed");

  // last marker sits on the final position of the frame
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_byte_index == (out_frame_length[4:0] - 5'd1))
    else $error("last flag on wrong byte index");

  // payload bursts out without gaps once the frame drains
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a payload burst");

  a_frame_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> $stable(out_frame_length))
    else $error("frame length changed within a burst");

endmodule

bind length_crc_frame_deframer_unit lcfd_checker u_lcfd_checker (.*);

// File: sim/length_crc_frame_deframer_checker.sv
// checker for the length/crc frame deframer: tracks frames on the input side and checks results
`timescale 1ns / 1ps

module length_crc_frame_deframer_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_payload_byte,
  input  logic [4:0] out_byte_index,
  input  logic [5:0] out_frame_length,
  input  logic       out_last,
  output int         mismatch_count,
  output int         awaited_count
);

  localparam int MAX_PAYLOAD = lcfd_pkg::MAX_PAYLOAD;

  typedef enum logic [3:0] {
    SEEK_MARKER  = 4'b0001,
    READ_LENGTH  = 4'b0010,
    READ_PAYLOAD = 4'b0100,
    READ_CHECK   = 4'b1000
  } frame_phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic [5:0] frame_length;
    logic       last;
  } payload_result_t;

  logic [7:0]      marker_value;
  frame_phase_t    frame_phase;
  logic [7:0]      frame_mem [MAX_PAYLOAD];
  logic [5:0]      stored_count;
  logic [5:0]      declared_len;
  logic [15:0]     crc_acc;
  logic            check_half;
  logic [7:0]      check_high;
  payload_result_t frame_results [$];

  // bitwise crc-16 ccitt-false, one message bit at a time
  function automatic logic [15:0] crc16_push(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ lcfd_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    payload_result_t r;
    case (frame_phase)
      SEEK_MARKER: begin
        if (b == marker_value) begin
          crc_acc      = crc16_push(lcfd_pkg::CRC_INIT, b);
          stored_count = '0;
          declared_len = '0;
          check_half   = 1'b0;
          check_high   = '0;
          frame_phase  = READ_LENGTH;
        end
      end
      READ_LENGTH: begin
        if (b >= 8'd1 && b <= MAX_PAYLOAD) begin
          declared_len = b[5:0];
          stored_count = '0;
          crc_acc      = crc16_push(crc_acc, b);
          frame_phase  = READ_PAYLOAD;
        end else begin
          // a rejected length byte is not re-examined as a start byte
          frame_phase = SEEK_MARKER;
        end
      end
      READ_PAYLOAD: begin
        frame_mem[stored_count[4:0]] = b;
        stored_count = stored_count + 6'd1;
        crc_acc = crc16_push(crc_acc, b);
        if (stored_count >= declared_len) begin
          check_half  = 1'b0;
          check_high  = '0;
          frame_phase = READ_CHECK;
        end
      end
      READ_CHECK: begin
        if (!check_half) begin
          check_high = b;
          check_half = 1'b1;
        end else begin
          check_half  = 1'b0;
          frame_phase = SEEK_MARKER;
          if ({check_high, b} == crc_acc) begin
            for (int i = 0; i < declared_len; i++) begin
              r.payload_byte = frame_mem[i];
              r.byte_index   = i[4:0];
              r.frame_length = declared_len;
              r.last         = (i + 1 == declared_len);
              frame_results.push_back(r);
            end
          end
        end
      end
      default: begin
        frame_phase = SEEK_MARKER;
      end
    endcase
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    payload_result_t want;
    if (!rst_n) begin
      marker_value = lcfd_pkg::MARKER_RESET;
      frame_phase  = SEEK_MARKER;
      stored_count = '0;
      declared_len = '0;
      crc_acc      = lcfd_pkg::CRC_INIT;
      check_half   = 1'b0;
      check_high   = '0;
      frame_results.delete();
    end else begin
      // a byte taken at the same edge as a marker write still sees the old marker
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte);
      end
      if (cfg_wr_en) begin
        marker_value = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        if (frame_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %h index %0d %s",
                   $time, out_payload_byte, out_byte_index,
                   $sformatf("length %0d last %b", out_frame_length, out_last));
          mismatch_count++;
        end else begin
          want = frame_results.pop_front();
          if (out_payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", want.payload_byte, out_payload_byte);
          if (out_byte_index !== want.byte_index)
            report_mismatch("byte_index", want.byte_index, out_byte_index);
          if (out_frame_length !== want.frame_length)
            report_mismatch("frame_length", want.frame_length, out_frame_length);
          if (out_last !== want.last)
            report_mismatch("last", want.last, out_last);
        end
      end
    end
    awaited_count <= frame_results.size();
  end

endmodule

// File: sim/length_crc_frame_deframer_unit_test.sv
// testbench top for the length/crc frame deframer: clock, reset, frame traffic and verdict
`timescale 1ns / 1ps

module length_crc_frame_deframer_unit_test;

  localparam int MAX_PAYLOAD    = lcfd_pkg::MAX_PAYLOAD;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_WAIT     = 8;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_SPARSE,
    RX_HEAVY,
    RX_LONG_STALLS
  } rx_stall_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid    = 1'b0;
  logic [7:0] in_rx_byte  = 8'h00;
  logic       out_ready   = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_payload_byte;
  logic [4:0] out_byte_index;
  logic [5:0] out_frame_length;
  logic       out_last;

  int         mismatch_count;
  int         awaited_count;
  int         quiet_cycles = 0;
  int         burst_left   = 0;
  int         stall_left   = 0;
  int         bytes_sent   = 0;
  rx_stall_t  stall_mode   = RX_ALWAYS;
  logic [7:0] marker_now;
  logic [7:0] frame_body [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  length_crc_frame_deframer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_payload_byte(out_payload_byte),
    .out_byte_index  (out_byte_index),
    .out_frame_length(out_frame_length),
    .out_last        (out_last)
  );

  length_crc_frame_deframer_checker frame_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_payload_byte(out_payload_byte),
    .out_byte_index  (out_byte_index),
    .out_frame_length(out_frame_length),
    .out_last        (out_last),
    .mismatch_count  (mismatch_count),
    .awaited_count   (awaited_count)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      case (stall_mode)
        RX_ALWAYS: begin
          out_ready <= 1'b1;
        end
        RX_SPARSE: begin
          out_ready <= ($urandom_range(0, 4) != 0);
        end
        RX_HEAVY: begin
          out_ready <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) begin
              stall_left <= $urandom_range(1, 10);
            end
          end
        end
      endcase
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("length_crc_frame_deframer_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one byte per transaction, sent in bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    int r;
    if (burst_left == 0) begin
      r   = $urandom_range(0, 99);
      gap = (r < 30) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(4, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame(input bit corrupt);
    logic [15:0] crc;
    logic [7:0]  len;
    len = 8'(frame_body.size());
    crc = lcfd_pkg::crc_feed(lcfd_pkg::CRC_INIT, marker_now);
    crc = lcfd_pkg::crc_feed(crc, len);
    foreach (frame_body[i]) crc = lcfd_pkg::crc_feed(crc, frame_body[i]);
    if (corrupt) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    send_byte(marker_now);
    send_byte(len);
    foreach (frame_body[i]) send_byte(frame_body[i]);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // mostly short payloads, now and then a full buffer
  function automatic void fill_body();
    int len;
    int r;
    r   = $urandom_range(0, 99);
    len = (r < 70) ? $urandom_range(1, 6) :
          (r < 92) ? $urandom_range(7, MAX_PAYLOAD - 1) : MAX_PAYLOAD;
    frame_body.delete();
    repeat (len) begin
      frame_body.push_back(($urandom_range(0, 9) == 0) ? marker_now : 8'($urandom));
    end
  endfunction

  task automatic run_random_traffic(input int quota);
    int         stop_at;
    int         pick;
    int         len;
    logic [7:0] bad_len;
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        fill_body();
        send_frame(pick >= 63);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 95) begin
        bad_len = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(MAX_PAYLOAD + 1, 255));
        send_byte(marker_now);
        send_byte(bad_len);
      end else begin
        // cut-off frame: what follows is swallowed as payload and crc
        len = $urandom_range(2, MAX_PAYLOAD);
        send_byte(marker_now);
        send_byte(8'(len));
        repeat ($urandom_range(1, len - 1)) send_byte(8'($urandom));
      end
    end
  endtask

  // wait until every result is out and the block has gone quiet
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_marker(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    marker_now = v;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    marker_now = lcfd_pkg::MARKER_RESET;
    stall_mode = RX_SPARSE;

    send_byte(8'h00);
    send_byte(8'hFF);
    frame_body = '{8'h00, 8'hFF};
    send_frame(1'b0);
    send_byte(marker_now);
    send_byte(8'h00);
    send_byte(marker_now);
    send_byte(8'(MAX_PAYLOAD + 1));
    send_byte(marker_now);
    send_byte(8'hFF);
    // start byte as length is rejected and not taken as a new start
    send_byte(marker_now);
    send_byte(marker_now);
    send_byte(8'h03);
    frame_body = '{8'h5A};
    send_frame(1'b1);
    frame_body = '{marker_now};
    send_frame(1'b0);
    settle();

    run_random_traffic(60);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_marker(8'h00);
        1: write_marker(8'hFF);
        2: write_marker(8'($urandom_range(1, MAX_PAYLOAD)));
        default: write_marker(lcfd_pkg::MARKER_RESET);
      endcase
      stall_mode = rx_stall_t'(p);
      run_random_traffic(65);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("length_crc_frame_deframer_unit verification clean");
    end else begin
      $display("length_crc_frame_deframer_unit verification failed");
    end
    $finish;
  end

endmodule
